### sv/sdr_pkg.sv
// ---------------------------------------------------------------------------
// sdr_pkg: shared types for the signed divide/remainder pipeline
// Operation codes, per-item control flags and the word carried cell to cell.
// ---------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned HalfW = 32;
    localparam int unsigned OpW   = 2;

    localparam logic [OpW-1:0] OP_QUO32 = 2'd0;
    localparam logic [OpW-1:0] OP_QUO64 = 2'd1;
    localparam logic [OpW-1:0] OP_REM32 = 2'd2;
    localparam logic [OpW-1:0] OP_REM64 = 2'd3;

    typedef struct packed {
        logic wide;      // 64-bit operation
        logic want_rem;  // remainder rather than quotient
        logic neg_q;     // operand signs differ
        logic neg_r;     // dividend negative
        logic dz;        // divisor zero at operation width
    } t_meta;

    typedef struct packed {
        logic [DataW-1:0] rem;  // partial remainder
        logic [DataW-1:0] quo;  // dividend bits still to shift in, quotient bits behind
        logic [DataW-1:0] dvs;  // divisor magnitude
        t_meta            meta;
    } t_stage;

endpackage

`default_nettype wire

### sv/sdr_prep.sv
// ---------------------------------------------------------------------------
// sdr_prep: operand preparation stage
// Reduces operands to the operation width, takes magnitudes, records signs.
// ---------------------------------------------------------------------------
`default_nettype none

module sdr_prep
    import sdr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [OpW-1:0]   i_opcode,
    input  wire logic [DataW-1:0] i_dividend,
    input  wire logic [DataW-1:0] i_divisor,
    output logic                  o_valid,
    output t_stage                o_data
);

    logic             r_valid;
    t_stage           r_data;
    t_stage           n_data;
    logic             wide;
    logic             na;
    logic             nb;
    logic [DataW-1:0] ua;
    logic [DataW-1:0] ub;
    logic [HalfW-1:0] a_lo_neg;
    logic [HalfW-1:0] b_lo_neg;

    always_comb begin
        wide     = (i_opcode == OP_QUO64) || (i_opcode == OP_REM64);
        na       = wide ? i_dividend[DataW-1] : i_dividend[HalfW-1];
        nb       = wide ? i_divisor[DataW-1]  : i_divisor[HalfW-1];
        a_lo_neg = -i_dividend[HalfW-1:0];
        b_lo_neg = -i_divisor[HalfW-1:0];
        if (wide) begin
            ua = na ? -i_dividend : i_dividend;
            ub = nb ? -i_divisor  : i_divisor;
        end else begin
            ua = {{(DataW-HalfW){1'b0}}, (na ? a_lo_neg : i_dividend[HalfW-1:0])};
            ub = {{(DataW-HalfW){1'b0}}, (nb ? b_lo_neg : i_divisor[HalfW-1:0])};
        end
        n_data.rem           = '0;
        n_data.quo           = ua;
        n_data.dvs           = ub;
        n_data.meta.wide     = wide;
        n_data.meta.want_rem = (i_opcode == OP_REM32) || (i_opcode == OP_REM64);
        n_data.meta.neg_q    = na ^ nb;
        n_data.meta.neg_r    = na;
        n_data.meta.dz       = (ub == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### sv/sdr_cell.sv
// ---------------------------------------------------------------------------
// sdr_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, trial-subtracts the
// divisor and shifts the quotient bit in.
// ---------------------------------------------------------------------------
`default_nettype none

module sdr_cell
    import sdr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_stage i_data,
    output logic        o_valid,
    output t_stage      o_data
);

    logic           r_valid;
    t_stage         r_data;
    t_stage         n_data;
    logic [DataW:0] trial;
    logic [DataW:0] diff;
    logic           fits;

    always_comb begin
        trial  = {i_data.rem, i_data.quo[DataW-1]};
        diff   = trial - {1'b0, i_data.dvs};
        // no borrow out of the trial subtract means the divisor fits
        fits   = !diff[DataW];
        n_data = i_data;
        n_data.rem = fits ? diff[DataW-1:0] : trial[DataW-1:0];
        n_data.quo = {i_data.quo[DataW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### sv/sdr_post.sv
// ---------------------------------------------------------------------------
// sdr_post: sign correction and output register
// Applies result signs, the divide-by-zero quotient and 32-bit extension.
// ---------------------------------------------------------------------------
`default_nettype none

module sdr_post
    import sdr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_stage            i_data,
    output logic                   o_valid,
    output logic [DataW-1:0]       o_result,
    output logic                   o_dz
);

    logic             r_valid;
    logic [DataW-1:0] r_result;
    logic             r_dz;
    logic [DataW-1:0] n_result;
    logic [DataW-1:0] res;

    always_comb begin
        if (i_data.meta.want_rem) begin
            res = i_data.meta.neg_r ? -i_data.rem : i_data.rem;
        end else if (i_data.meta.dz) begin
            res = '1;
        end else begin
            res = i_data.meta.neg_q ? -i_data.quo : i_data.quo;
        end
        n_result = i_data.meta.wide ? res
                 : {{(DataW-HalfW){res[HalfW-1]}}, res[HalfW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
            r_dz     <= i_data.meta.dz;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_dz     = r_dz;

endmodule

`default_nettype wire

### sv/signed_divide_remainder.sv
// ---------------------------------------------------------------------------
// signed_divide_remainder: pipelined truncating signed divider, 32/64 bit
// Input stream: tuser carries the opcode (quotient/remainder, 32/64 bit),
// tdata the dividend and divisor. Output stream: tdata the sign-extended
// quotient or remainder, tuser the divide-by-zero flag.
// From transfer in to result valid an operation passes one preparation
// stage, a row of 64 restoring-division cells (one quotient bit each, one
// 65-bit subtract and compare per cell) and the output register.
// Throughput is one operation per cycle; a new transfer is taken every cycle
// that the output register is empty or being drained.
// When the receiver holds tready low with a result waiting, the whole row
// holds its contents and s_tready drops; nothing is lost or repeated.
// Division by zero sets the flag, gives a quotient of all ones and a
// remainder equal to the dividend. Most negative over minus one wraps.
// Reset empties the pipeline; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_divide_remainder
    import sdr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [2*DataW-1:0] i_s_tdata,   // [63:0] dividend, [127:64] divisor
    input  wire logic [OpW-1:0]     i_s_tuser,   // [1:0] opcode
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [DataW-1:0]        o_m_tdata,   // [63:0] result
    output logic                    o_m_tuser    // [0] divide_by_zero
);

    logic   en;
    logic   c_valid [0:DataW];
    t_stage c_data  [0:DataW];

    // whole row advances together whenever the output slot is free
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    sdr_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_s_tvalid),
        .i_opcode   (i_s_tuser),
        .i_dividend (i_s_tdata[DataW-1:0]),
        .i_divisor  (i_s_tdata[2*DataW-1:DataW]),
        .o_valid    (c_valid[0]),
        .o_data     (c_data[0])
    );

    for (genvar g = 0; g < DataW; g++) begin : g_cell
        sdr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    sdr_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (c_valid[DataW]),
        .i_data   (c_data[DataW]),
        .o_valid  (o_m_tvalid),
        .o_result (o_m_tdata),
        .o_dz     (o_m_tuser)
    );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for signed_divide_remainder
// Drives quotient/remainder operations at both widths, first from a table of
// edge cases, then at random, under several patterns of source gaps and sink
// back-pressure. Each result transfer is compared, in order, with an in-bench
// model of truncating signed division or with an answer worked out by hand.
// ---------------------------------------------------------------------------

module tb;
    import sdr_pkg::*;

    localparam logic [DataW-1:0] Min64  = 64'h8000_0000_0000_0000;
    localparam logic [DataW-1:0] Max64  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DataW-1:0] NegOne = '1;
    localparam logic [DataW-1:0] Low32  = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned IdleLimit   = 4000;
    localparam int unsigned DrainCycles = 80;
    localparam int unsigned ItemsPerPhase = 163;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             dz;
    } t_div_result;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
        logic             typed;  // want is given here rather than predicted
        t_div_result      want;
    } t_op_row;

    // Edge cases; rows with typed set carry the answer worked out by hand
    localparam t_op_row EdgeRows [22] = '{
        '{OP_QUO64, 64'd100, 64'd7, 1'b0, '0},
        '{OP_REM64, -64'sd100, 64'd7, 1'b0, '0},
        '{OP_QUO32, -64'sd7, 64'd2, 1'b0, '0},
        '{OP_REM32, 64'd7, -64'sd2, 1'b0, '0},
        '{OP_QUO64, Min64, NegOne, 1'b1, '{Min64, 1'b0}},
        '{OP_REM64, Min64, NegOne, 1'b1, '{64'd0, 1'b0}},
        '{OP_QUO32, 64'h1234_5678_8000_0000, 64'hABCD_0000_FFFF_FFFF, 1'b1,
          '{64'hFFFF_FFFF_8000_0000, 1'b0}},
        '{OP_REM32, 64'h1234_5678_8000_0000, 64'hABCD_0000_FFFF_FFFF, 1'b1,
          '{64'd0, 1'b0}},
        '{OP_QUO64, 64'd12345, 64'd0, 1'b1, '{NegOne, 1'b1}},
        '{OP_REM64, Min64, 64'd0, 1'b1, '{Min64, 1'b1}},
        '{OP_QUO32, 64'd5, 64'hFFFF_FFFF_0000_0000, 1'b1, '{NegOne, 1'b1}},
        '{OP_REM32, 64'h0000_0000_8000_0001, 64'h7777_7777_0000_0000, 1'b1,
          '{64'hFFFF_FFFF_8000_0001, 1'b1}},
        '{OP_QUO64, Max64, Max64, 1'b1, '{64'd1, 1'b0}},
        '{OP_QUO64, Max64, Min64, 1'b1, '{64'd0, 1'b0}},
        '{OP_REM64, Max64, Min64, 1'b1, '{Max64, 1'b0}},
        '{OP_QUO64, Min64, Min64, 1'b1, '{64'd1, 1'b0}},
        '{OP_QUO64, Min64, 64'd1, 1'b1, '{Min64, 1'b0}},
        '{OP_QUO32, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000, 1'b1,
          '{64'd0, 1'b0}},
        '{OP_QUO32, 64'h0000_0000_8000_0000, 64'd1, 1'b1,
          '{64'hFFFF_FFFF_8000_0000, 1'b0}},
        '{OP_REM64, 64'd0, NegOne, 1'b1, '{64'd0, 1'b0}},
        '{OP_QUO32, NegOne, NegOne, 1'b0, '0},
        '{OP_REM64, 64'hDEAD_BEEF_0123_4567, 64'h0000_0000_0001_0003, 1'b0, '0}
    };

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [2*DataW-1:0]  s_tdata = '0;
    logic [OpW-1:0]      s_tuser = '0;
    logic                m_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [DataW-1:0]    o_m_tdata;
    logic                o_m_tuser;

    t_div_result         pending_q [$];
    int unsigned         src_idle_pct = 0;
    int unsigned         sink_stall_pct = 0;
    int unsigned         n_sent = 0;
    int unsigned         n_checked = 0;
    int unsigned         n_dz = 0;
    int unsigned         n_errors = 0;

    signed_divide_remainder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // [63:0] dividend, [127:64] divisor
        .i_s_tuser  (s_tuser),     // [1:0] opcode
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),   // [63:0] result
        .o_m_tuser  (o_m_tuser)    // [0] divide_by_zero
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // Truncating signed divide at 32 or 64 bits, divide by zero patched up
    function automatic t_div_result signed_divide(input logic [OpW-1:0] op,
                                                  input logic [DataW-1:0] a_in,
                                                  input logic [DataW-1:0] b_in);
        t_div_result      res;
        logic             wide;
        logic             want_rem;
        logic             neg_a;
        logic             neg_b;
        logic [DataW-1:0] mask;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] mag_a;
        logic [DataW-1:0] mag_b;
        logic [DataW-1:0] quo;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] raw;
        wide     = (op == OP_QUO64) || (op == OP_REM64);
        want_rem = (op == OP_REM32) || (op == OP_REM64);
        mask     = wide ? NegOne : Low32;
        a        = a_in & mask;
        b        = b_in & mask;
        neg_a    = wide ? a[DataW-1] : a[HalfW-1];
        neg_b    = wide ? b[DataW-1] : b[HalfW-1];
        if (b == '0) begin
            res.dz = 1'b1;
            raw    = want_rem ? a : mask;
        end else begin
            res.dz = 1'b0;
            mag_a  = neg_a ? ((-a) & mask) : a;
            mag_b  = neg_b ? ((-b) & mask) : b;
            quo    = mag_a / mag_b;
            rem    = mag_a % mag_b;
            if (want_rem)
                raw = neg_a ? ((-rem) & mask) : rem;
            else
                raw = (neg_a != neg_b) ? ((-quo) & mask) : quo;
        end
        res.value = wide ? raw : {{HalfW{raw[HalfW-1]}}, raw[HalfW-1:0]};
        return res;
    endfunction

    // Operand mix: extremes, 32-bit edge values under random upper halves,
    // magnitudes of every size, and plain random words
    function automatic logic [DataW-1:0] pick_operand();
        logic [DataW-1:0] v;
        int unsigned      kind;
        v    = {$urandom, $urandom};
        kind = $urandom_range(15);
        case (kind)
            0: v = '0;
            1: v = Min64;
            2: v = Max64;
            3: v = NegOne;
            4: v = 64'd1;
            5: v = {v[DataW-1:HalfW], 32'h8000_0000};
            6: v = {v[DataW-1:HalfW], 32'hFFFF_FFFF};
            7: v = {v[DataW-1:HalfW], 32'h0000_0000};
            8, 9, 10, 11: begin
                v = v >> $urandom_range(DataW-1);
                if ($urandom_range(1) == 1)
                    v = -v;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_op(input logic [OpW-1:0] op, input logic [DataW-1:0] a,
                           input logic [DataW-1:0] b, input t_div_result want);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if (o_s_tready) begin
                taken = 1'b1;
                pending_q.push_back(want);
                n_sent++;
            end
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checker; everything is stable at the falling edge
    always @(negedge i_clk) begin
        t_div_result exp_res;
        if (rst_n && o_m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result transfer: value %h dz %b", o_m_tdata,
                             o_m_tuser);
            end else begin
                exp_res = pending_q.pop_front();
                n_checked++;
                if (o_m_tuser)
                    n_dz++;
                if (o_m_tdata !== exp_res.value || o_m_tuser !== exp_res.dz) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch on result %0d: expected %h dz %b, got %h dz %b",
                                 n_checked, exp_res.value, exp_res.dz, o_m_tdata,
                                 o_m_tuser);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < IdleLimit) begin
            @(negedge i_clk);
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("tb: errors");
        $finish;
    end

    initial begin : stimulus
        logic [OpW-1:0]   op;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        t_div_result      want;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (EdgeRows[i]) begin
            want = EdgeRows[i].typed ? EdgeRows[i].want
                 : signed_divide(EdgeRows[i].op, EdgeRows[i].dividend, EdgeRows[i].divisor);
            send_op(EdgeRows[i].op, EdgeRows[i].dividend, EdgeRows[i].divisor, want);
        end

        // phases: free running, source gaps, sink stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct   = (phase == 1) ? 59 : (phase == 3) ? 29 : 0;
            sink_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 29 : 0;
            for (int n = 0; n < ItemsPerPhase; n++) begin
                op = OpW'($urandom_range(3));
                a  = pick_operand();
                b  = pick_operand();
                send_op(op, a, b, signed_divide(op, a, b));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        n_errors += pending_q.size();

        $display("%0d operations sent, %0d results checked (%0d divide by zero),",
                 n_sent, n_checked, n_dz);
        $display("both widths, edge table then random under gaps and back-pressure");
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### files.f
sv/sdr_pkg.sv
sv/sdr_prep.sv
sv/sdr_cell.sv
sv/sdr_post.sv
sv/signed_divide_remainder.sv
tb/tb.sv
